[src/rrfp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrfp_pkg
// Types, codes and helper functions shared by the reader response frame
// parser modules.
// ----------------------------------------------------------------------------
package rrfp_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_GOOD    = 2'd1;
  localparam logic [1:0] KIND_CRC_BAD = 2'd2;
  localparam logic [1:0] KIND_ABORT   = 2'd3;

  // Input item functions.
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TIMEOUT_TICKS     = 2'd0;
  localparam logic [1:0] CFG_PREAMBLE_VALUE    = 2'd1;
  localparam logic [1:0] CFG_RESPONSE_TYPE     = 2'd2;
  localparam logic [1:0] CFG_NOTIFICATION_TYPE = 2'd3;

  localparam logic [3:0]  CLASS_NONE = 4'd11;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'h1021;

  // Result queue depth; room for two results of one item plus slack.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [8:0]  position;
    logic [7:0]  frame_byte;
    logic [7:0]  frame_type;
    logic [3:0]  response_class;
    logic [15:0] payload_length;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [7:0]  preamble_value;
    logic [7:0]  response_type;
    logic [7:0]  notification_type;
  } cfg_t;

  // Results produced by one item, handed to the result queue.
  typedef struct packed {
    logic [1:0] n;
    out_item_t  r0;
    out_item_t  r1;
  } push_t;

  // One byte of CRC-16/CCITT-FALSE, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                           input logic [7:0]  b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else       c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // Index of the first table entry equal to the code byte.
  function automatic logic [3:0] class_of(input logic [7:0] code);
    logic [3:0] cls;
    cls = CLASS_NONE;
    priority case (code)
      8'h08:   cls = 4'd0;
      8'h34:   cls = 4'd1;
      8'h0D:   cls = 4'd2;
      8'h03:   cls = 4'd3;
      8'h15:   cls = 4'd4;
      8'h16:   cls = 4'd5;
      8'h06:   cls = 4'd6;
      8'h07:   cls = 4'd7;
      8'h13:   cls = 4'd8;
      8'h36:   cls = 4'd9;
      8'h37:   cls = 4'd10;
      default: cls = CLASS_NONE;
    endcase
    return cls;
  endfunction

endpackage

[src/rrfp_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrfp_core
// Input register and the per-item frame parsing step: phase tracking,
// CRC update, timeout counting and result generation.
// ----------------------------------------------------------------------------
module rrfp_core
  import rrfp_pkg::*;
#(
  parameter int unsigned MAX_FRAME = 512
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_item_i,
  input  logic [2:0] space_i,
  output push_t      push_o
);

  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_TYPE  = 3'd1;
  localparam logic [2:0] PH_CODE  = 3'd2;
  localparam logic [2:0] PH_LENH  = 3'd3;
  localparam logic [2:0] PH_LENL  = 3'd4;
  localparam logic [2:0] PH_PAY   = 3'd5;
  localparam logic [2:0] PH_TRAIL = 3'd6;

  localparam logic [16:0] MaxFrameW = 17'(MAX_FRAME);
  localparam logic [16:0] HeaderW   = 17'd8;

  logic        in_valid_q;
  in_item_t    in_q;
  logic        fire;

  logic [2:0]  phase_q, phase_d;
  logic [8:0]  pos_q, pos_d;
  logic [15:0] payrem_q, payrem_d;
  logic [1:0]  trailer_q, trailer_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  code_q, code_d;
  logic [7:0]  lenh_q, lenh_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [15:0] flen_q, flen_d;

  logic [1:0]  n;
  out_item_t   r0, r1;
  logic [15:0] el_inc;
  logic [15:0] new_len;
  logic [1:0]  trail_dec;
  logic        to_hunt;

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    payrem_d  = payrem_q;
    trailer_d = trailer_q;
    crc_d     = crc_q;
    type_d    = type_q;
    code_d    = code_q;
    lenh_d    = lenh_q;
    elapsed_d = elapsed_q;
    flen_d    = flen_q;
    to_hunt   = 1'b0;
    n         = 2'd0;
    el_inc    = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
    new_len   = {lenh_q, in_q.rx_byte};
    trail_dec = (trailer_q != 2'd0) ? trailer_q - 2'd1 : 2'd0;

    r0 = '{kind: KIND_BYTE, position: pos_q, frame_byte: in_q.rx_byte,
           frame_type: 8'd0, response_class: CLASS_NONE,
           payload_length: 16'd0, last: 1'b0};
    r1 = '{kind: KIND_ABORT, position: pos_q + 9'd1, frame_byte: 8'd0,
           frame_type: 8'd0, response_class: CLASS_NONE,
           payload_length: 16'd0, last: 1'b0};

    if (in_q.func == FUNC_TICK) begin
      if (phase_q != PH_HUNT) begin
        elapsed_d = el_inc;
        if (el_inc >= cfg_i.timeout_ticks) begin
          r0.kind       = KIND_ABORT;
          r0.frame_byte = 8'd0;
          n             = 2'd1;
          to_hunt       = 1'b1;
        end
      end
    end else if (phase_q == PH_HUNT || phase_q > PH_TRAIL) begin
      if (in_q.rx_byte == cfg_i.preamble_value) begin
        type_d    = 8'd0;
        code_d    = 8'd0;
        lenh_d    = 8'd0;
        flen_d    = 16'd0;
        crc_d     = CRC_INIT;
        elapsed_d = 16'd0;
        r0.position = 9'd0;
        pos_d     = 9'd1;
        phase_d   = PH_TYPE;
        n         = 2'd1;
      end else begin
        // An illegal phase code falls back to hunting.
        to_hunt = (phase_q != PH_HUNT);
      end
    end else begin
      crc_d = crc_byte(crc_q, in_q.rx_byte);
      pos_d = pos_q + 9'd1;
      n     = 2'd1;
      unique case (phase_q)
        PH_TYPE: begin
          type_d    = in_q.rx_byte;
          elapsed_d = 16'd0;
          if (in_q.rx_byte != cfg_i.response_type &&
              in_q.rx_byte != cfg_i.notification_type) begin
            n       = 2'd2;
            to_hunt = 1'b1;
          end else begin
            phase_d = PH_CODE;
          end
        end
        PH_CODE: begin
          code_d  = in_q.rx_byte;
          phase_d = PH_LENH;
        end
        PH_LENH: begin
          lenh_d  = in_q.rx_byte;
          phase_d = PH_LENL;
        end
        PH_LENL: begin
          flen_d = new_len;
          if ({1'b0, new_len} + HeaderW > MaxFrameW) begin
            n       = 2'd2;
            to_hunt = 1'b1;
          end else if (new_len == 16'd0) begin
            trailer_d = 2'd3;
            phase_d   = PH_TRAIL;
          end else begin
            payrem_d = new_len;
            phase_d  = PH_PAY;
          end
        end
        PH_PAY: begin
          payrem_d = payrem_q - 16'd1;
          if (payrem_d == 16'd0) begin
            trailer_d = 2'd3;
            phase_d   = PH_TRAIL;
          end
        end
        default: begin
          trailer_d = trail_dec;
          if (trail_dec == 2'd0) begin
            r1.kind           = (crc_d == 16'd0) ? KIND_GOOD : KIND_CRC_BAD;
            r1.position       = pos_q;
            r1.response_class = class_of(code_q);
            r1.payload_length = flen_q;
            n                 = 2'd2;
            to_hunt           = 1'b1;
          end
        end
      endcase
    end

    if (to_hunt) begin
      phase_d   = PH_HUNT;
      pos_d     = 9'd0;
      payrem_d  = 16'd0;
      trailer_d = 2'd0;
      elapsed_d = 16'd0;
    end

    r0.frame_type = type_d;
    r1.frame_type = type_d;
    r0.last       = (n == 2'd1);
    r1.last       = 1'b1;
  end

  assign fire       = in_valid_q && ({1'b0, n} <= space_i);
  assign in_stall_o = in_valid_q && !fire;

  always_comb begin
    push_o.n  = fire ? n : 2'd0;
    push_o.r0 = r0;
    push_o.r1 = r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      pos_q     <= 9'd0;
      payrem_q  <= 16'd0;
      trailer_q <= 2'd0;
      crc_q     <= CRC_INIT;
      type_q    <= 8'd0;
      code_q    <= 8'd0;
      lenh_q    <= 8'd0;
      elapsed_q <= 16'd0;
      flen_q    <= 16'd0;
    end else if (fire) begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      payrem_q  <= payrem_d;
      trailer_q <= trailer_d;
      crc_q     <= crc_d;
      type_q    <= type_d;
      code_q    <= code_d;
      lenh_q    <= lenh_d;
      elapsed_q <= elapsed_d;
      flen_q    <= flen_d;
    end
  end

  // While hunting no frame is open, so position and tick count are clear.
  a_hunt_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HUNT) |-> (pos_q == 9'd0 && elapsed_q == 16'd0))
    else $error("hunting with frame counters not cleared");

  // The trailer count is only live inside the trailer.
  a_trailer_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (trailer_q != 2'd0) |-> (phase_q == PH_TRAIL))
    else $error("trailer count set outside the trailer phase");

  // A pair of results is always an echoed byte followed by a frame-ending result.
  a_pair_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.n == 2'd2) |-> (push_o.r0.kind == KIND_BYTE && !push_o.r0.last &&
                            push_o.r1.kind != KIND_BYTE && phase_d == PH_HUNT))
    else $error("malformed result pair");

endmodule

[src/rrfp_out_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrfp_out_fifo
// Result queue: takes up to two results per cycle from the parser and
// hands them out one per cycle on the output channel unless out_stall_i is set.
// ----------------------------------------------------------------------------
module rrfp_out_fifo
  import rrfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  push_t      push_i,
  output logic [2:0] space_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_item_o
);

  localparam logic [2:0] Depth = 3'(FIFO_DEPTH);

  out_item_t          mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [2:0]         count_q;
  logic               pop;

  assign out_valid_o = (count_q != 3'd0);
  assign out_item_o  = mem_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;
  // Free entries once this cycle's pop has left.
  assign space_o     = Depth - count_q + {2'b00, pop};

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_q + FIFO_AW'(1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= 3'd0;
    end else begin
      wr_q    <= wr_q + FIFO_AW'(push_i.n);
      rd_q    <= rd_q + FIFO_AW'(pop);
      count_q <= count_q - {2'b00, pop} + {1'b0, push_i.n};
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Depth)
    else $error("result queue overflow");

  a_push_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, push_i.n} <= space_o)
    else $error("results pushed without room");

endmodule

[src/reader_response_frame_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reader_response_frame_parser
// Preamble / length framed receiver with CRC-16/CCITT-FALSE check, byte
// echo, timeout and frame verdict.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_stall_o  in_item_t (func, rx_byte)
// out      output     out_valid_o/out_stall_i out_item_t (kind .. last)
// cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// An item is registered, parsed combinationally and its results, none, one or
// two, go into a four-entry result queue; one item can be taken every cycle
// while the queue has room. The queue drains one result per cycle while
// out_stall_i is low, so an item is held at the input while the queue has
// fewer free entries than the results it yields.
// Reset clears the frame state, the queue and loads the register defaults.
// Output stalls back up through the queue to in_stall_o.
// ----------------------------------------------------------------------------
module reader_response_frame_parser
  import rrfp_pkg::*;
#(
  parameter int unsigned MAX_FRAME = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t       cfg_q;
  push_t      push;
  logic [2:0] space;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ticks     <= 16'd300;
      cfg_q.preamble_value    <= 8'hBB;
      cfg_q.response_type     <= 8'd1;
      cfg_q.notification_type <= 8'd2;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_TIMEOUT_TICKS:     cfg_q.timeout_ticks     <= cfg_data_i;
        CFG_PREAMBLE_VALUE:    cfg_q.preamble_value    <= cfg_data_i[7:0];
        CFG_RESPONSE_TYPE:     cfg_q.response_type     <= cfg_data_i[7:0];
        CFG_NOTIFICATION_TYPE: cfg_q.notification_type <= cfg_data_i[7:0];
        default:               cfg_q                   <= cfg_q;
      endcase
    end
  end

  rrfp_core #(
    .MAX_FRAME (MAX_FRAME)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .space_i    (space),
    .push_o     (push)
  );

  rrfp_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
